// ===== hdl/rpac_pkg.sv =====
`timescale 1ns / 1ps
// rpac_pkg: shared types, widths and constants for the point rotation block.
// No dependencies; used by every module of the block.

package rpac_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int NUM_STEPS    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int GUARD_BITS   = 2;

    localparam int ANGLE_WIDTH  = 16;
    localparam int OFS_WIDTH    = COORD_WIDTH + 1;
    localparam int XY_WIDTH     = COORD_WIDTH + GUARD_BITS + 4;
    localparam int Z_WIDTH      = 32;
    localparam int SUM_WIDTH    = XY_WIDTH + 1;

    localparam int GAIN_WIDTH   = 30;
    localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;
    localparam int LO_SPLIT     = 20;
    localparam int HI_WIDTH     = XY_WIDTH - LO_SPLIT;
    localparam int ROUND_SHIFT  = 30 + GUARD_BITS - LO_SPLIT;
    localparam int PH_WIDTH     = HI_WIDTH + GAIN_WIDTH;
    localparam int PL_WIDTH     = LO_SPLIT + GAIN_WIDTH;
    localparam int T_WIDTH      = PH_WIDTH + 1;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] QUAD_NONE    = 2'd0;
    localparam logic [1:0] QUAD_QUARTER = 2'd1;
    localparam logic [1:0] QUAD_HALF    = 2'd2;
    localparam logic [1:0] QUAD_THREE   = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic        [ANGLE_WIDTH-1:0] turn_angle;
    } request_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
    } result_t;

    // offset after the exact quarter-turn, residual angle, and center
    typedef struct packed {
        logic signed [OFS_WIDTH-1:0]   ofs_x;
        logic signed [OFS_WIDTH-1:0]   ofs_y;
        logic signed [ANGLE_WIDTH-1:0] residual;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
    } job_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_WIDTH-1:0] atan_turn(input int idx);
        logic signed [Z_WIDTH-1:0] val;
        case (idx)
            0:       val = 32'sd536870912;
            1:       val = 32'sd316933406;
            2:       val = 32'sd167458907;
            3:       val = 32'sd85004756;
            4:       val = 32'sd42667331;
            5:       val = 32'sd21354465;
            6:       val = 32'sd10679838;
            7:       val = 32'sd5340245;
            8:       val = 32'sd2670163;
            9:       val = 32'sd1335087;
            10:      val = 32'sd667544;
            11:      val = 32'sd333772;
            12:      val = 32'sd166886;
            13:      val = 32'sd83443;
            14:      val = 32'sd41722;
            15:      val = 32'sd20861;
            16:      val = 32'sd10430;
            17:      val = 32'sd5215;
            18:      val = 32'sd2608;
            19:      val = 32'sd1304;
            20:      val = 32'sd652;
            21:      val = 32'sd326;
            22:      val = 32'sd163;
            23:      val = 32'sd81;
            24:      val = 32'sd41;
            25:      val = 32'sd20;
            26:      val = 32'sd10;
            27:      val = 32'sd5;
            28:      val = 32'sd3;
            29:      val = 32'sd1;
            30:      val = 32'sd1;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/rotate_point_about_center.sv =====
`timescale 1ns / 1ps
// rotate_point_about_center: top level of the point rotation block.
// Depends on rpac_pkg, rpac_front, rpac_queue and rpac_back.
//
// Usage:
//   Request channel: drive request (point, center, clockwise binary angle) and
//   raise push; the request is taken at a clock edge where push is high and
//   full is low.
//   Result channel: while empty is low, result holds the oldest rotated point;
//   raise pop to take it at a clock edge where empty is low.
//   Path: a request passes through the job queue, the 16-step CORDIC pipeline
//   and the gain-removal multiplier stages before its result becomes visible.
//   Throughput: one request per cycle while the result buffer is not full; all
//   pipeline stages advance together, gated only by the two-entry result buffer.
//   Stall: when the result buffer is full the pipeline holds, the four-entry
//   job queue fills, and full rises once it is exhausted.
//   Reset: rst_n clears all queues and stage valid flags; no requests are
//   in flight afterwards and empty is high.

module rotate_point_about_center
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rpac_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output rpac_pkg::result_t result
);

    rpac_pkg::job_t front_job;
    rpac_pkg::job_t queue_job;
    logic           queue_empty;
    logic           queue_pop;

    rpac_front u_front
    (
        .request (request),
        .job     (front_job)
    );

    rpac_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_job  (front_job),
        .pop     (queue_pop),
        .empty   (queue_empty),
        .rd_job  (queue_job)
    );

    rpac_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (queue_empty),
        .job_pop   (queue_pop),
        .job       (queue_job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== hdl/rpac_front.sv =====
`timescale 1ns / 1ps
// rpac_front: forms the offset from the center, picks the quadrant and applies
// the exact quarter-turn pre-rotation. Depends on rpac_pkg.

module rpac_front
(
    input  rpac_pkg::request_t request,
    output rpac_pkg::job_t     job
);

    logic [rpac_pkg::ANGLE_WIDTH-1:0]      shifted;
    logic [1:0]                            quad;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] px;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] py;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] cx;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] cy;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] dx;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] dy;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] ndx;
    logic signed [rpac_pkg::OFS_WIDTH-1:0] ndy;

    assign shifted = request.turn_angle + 16'h2000;
    assign quad    = shifted[15:14];

    assign px  = rpac_pkg::OFS_WIDTH'(request.point_x);
    assign py  = rpac_pkg::OFS_WIDTH'(request.point_y);
    assign cx  = rpac_pkg::OFS_WIDTH'(request.center_x);
    assign cy  = rpac_pkg::OFS_WIDTH'(request.center_y);
    assign dx  = px - cx;
    assign dy  = py - cy;
    assign ndx = cx - px;
    assign ndy = cy - py;

    always_comb
    begin
        job.residual = {2'(request.turn_angle[15:14] - quad), request.turn_angle[13:0]};
        job.center_x = request.center_x;
        job.center_y = request.center_y;
        case (quad)
            rpac_pkg::QUAD_NONE:
            begin
                job.ofs_x = dx;
                job.ofs_y = dy;
            end
            rpac_pkg::QUAD_QUARTER:
            begin
                job.ofs_x = dy;
                job.ofs_y = ndx;
            end
            rpac_pkg::QUAD_HALF:
            begin
                job.ofs_x = ndx;
                job.ofs_y = ndy;
            end
            rpac_pkg::QUAD_THREE:
            begin
                job.ofs_x = ndy;
                job.ofs_y = dx;
            end
            default:
            begin
                job.ofs_x = dx;
                job.ofs_y = dy;
            end
        endcase
    end

endmodule

// ===== hdl/rpac_queue.sv =====
`timescale 1ns / 1ps
// rpac_queue: short first-in first-out queue of jobs between front and back.
// Depends on rpac_pkg.

module rpac_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  rpac_pkg::job_t wr_job,
    input  logic           pop,
    output logic           empty,
    output rpac_pkg::job_t rd_job
);

    rpac_pkg::job_t                    slot_reg [0:rpac_pkg::QUEUE_DEPTH-1];
    logic [rpac_pkg::QPTR_WIDTH-1:0]   wptr_reg;
    logic [rpac_pkg::QPTR_WIDTH-1:0]   wptr_next;
    logic [rpac_pkg::QPTR_WIDTH-1:0]   rptr_reg;
    logic [rpac_pkg::QPTR_WIDTH-1:0]   rptr_next;
    logic [rpac_pkg::QCNT_WIDTH-1:0]   cnt_reg;
    logic [rpac_pkg::QCNT_WIDTH-1:0]   cnt_next;
    logic                              wr_en;
    logic                              rd_en;

    assign full   = (cnt_reg == rpac_pkg::QCNT_WIDTH'(rpac_pkg::QUEUE_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign wr_en  = push && !full;
    assign rd_en  = pop && !empty;
    assign rd_job = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end

endmodule

// ===== hdl/rpac_back.sv =====
`timescale 1ns / 1ps
// rpac_back: CORDIC micro-rotation pipeline, gain removal, center add,
// saturation and a two-entry result buffer. Depends on rpac_pkg.

module rpac_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_empty,
    output logic              job_pop,
    input  rpac_pkg::job_t    job,
    output logic              empty,
    input  logic              pop,
    output rpac_pkg::result_t result
);

    localparam int N  = rpac_pkg::NUM_STEPS;
    localparam int XW = rpac_pkg::XY_WIDTH;
    localparam int ZW = rpac_pkg::Z_WIDTH;
    localparam int CW = rpac_pkg::COORD_WIDTH;
    localparam int SW = rpac_pkg::SUM_WIDTH;
    localparam int LS = rpac_pkg::LO_SPLIT;
    localparam int RS = rpac_pkg::ROUND_SHIFT;
    localparam int TW = rpac_pkg::T_WIDTH;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    logic                   advance;
    logic [N:0]             vld_reg;
    logic [3:0]             pv_reg;
    logic signed [XW-1:0]   x_reg  [0:N];
    logic signed [XW-1:0]   y_reg  [0:N];
    logic signed [ZW-1:0]   z_reg  [0:N];
    logic signed [CW-1:0]   cx_reg [0:N];
    logic signed [CW-1:0]   cy_reg [0:N];

    logic [XW-1:0]          mx_reg;
    logic [XW-1:0]          my_reg;
    logic [1:0]             neg_reg;
    logic signed [CW-1:0]   pcx_reg [0:3];
    logic signed [CW-1:0]   pcy_reg [0:3];
    logic [rpac_pkg::PH_WIDTH-1:0] phx_reg;
    logic [rpac_pkg::PH_WIDTH-1:0] phy_reg;
    logic [rpac_pkg::PL_WIDTH-1:0] plx_reg;
    logic [rpac_pkg::PL_WIDTH-1:0] ply_reg;
    logic [TW-1:0]          tx_reg;
    logic [TW-1:0]          ty_reg;
    logic [XW-1:0]          rx_reg;
    logic [XW-1:0]          ry_reg;
    logic [2:0]             negx_reg;
    logic [2:0]             negy_reg;

    logic signed [SW-1:0]   sum_x;
    logic signed [SW-1:0]   sum_y;
    rpac_pkg::result_t      res_next;

    rpac_pkg::result_t      obuf_reg [0:1];
    logic                   owr_reg;
    logic                   ord_reg;
    logic [1:0]             ocnt_reg;
    logic [1:0]             ocnt_next;
    logic                   out_full;
    logic                   out_push;
    logic                   out_pop;

    assign out_full = (ocnt_reg == 2'd2);
    assign advance  = !pv_reg[3] || !out_full;
    assign job_pop  = advance && !job_empty;
    assign out_push = pv_reg[3] && !out_full;
    assign out_pop  = pop && !empty;
    assign empty    = (ocnt_reg == 2'd0);
    assign result   = obuf_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            pv_reg  <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[N-1:0], !job_empty};
            pv_reg  <= {pv_reg[2:0], vld_reg[N]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]  <= XW'(job.ofs_x) <<< rpac_pkg::GUARD_BITS;
            y_reg[0]  <= XW'(job.ofs_y) <<< rpac_pkg::GUARD_BITS;
            z_reg[0]  <= {job.residual, {(ZW-rpac_pkg::ANGLE_WIDTH){1'b0}}};
            cx_reg[0] <= job.center_x;
            cy_reg[0] <= job.center_y;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        localparam logic signed [ZW-1:0] ANG = rpac_pkg::atan_turn(k - 1);
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic                 ccw;

        assign xs  = x_reg[k-1] >>> (k - 1);
        assign ys  = y_reg[k-1] >>> (k - 1);
        assign ccw = z_reg[k-1][ZW-1];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[k]  <= ccw ? x_reg[k-1] - ys : x_reg[k-1] + ys;
                y_reg[k]  <= ccw ? y_reg[k-1] + xs : y_reg[k-1] - xs;
                z_reg[k]  <= ccw ? z_reg[k-1] + ANG : z_reg[k-1] - ANG;
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
        end
    end

    // gain removal: magnitude, split products, sum, round
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx_reg     <= x_reg[N][XW-1] ? XW'(-x_reg[N]) : XW'(x_reg[N]);
            my_reg     <= y_reg[N][XW-1] ? XW'(-y_reg[N]) : XW'(y_reg[N]);
            neg_reg    <= {y_reg[N][XW-1], x_reg[N][XW-1]};
            pcx_reg[0] <= cx_reg[N];
            pcy_reg[0] <= cy_reg[N];

            phx_reg <= rpac_pkg::PH_WIDTH'(mx_reg[XW-1:LS]) *
                       rpac_pkg::PH_WIDTH'(rpac_pkg::GAIN_Q30);
            phy_reg <= rpac_pkg::PH_WIDTH'(my_reg[XW-1:LS]) *
                       rpac_pkg::PH_WIDTH'(rpac_pkg::GAIN_Q30);
            plx_reg <= rpac_pkg::PL_WIDTH'(mx_reg[LS-1:0]) *
                       rpac_pkg::PL_WIDTH'(rpac_pkg::GAIN_Q30);
            ply_reg <= rpac_pkg::PL_WIDTH'(my_reg[LS-1:0]) *
                       rpac_pkg::PL_WIDTH'(rpac_pkg::GAIN_Q30);
            negx_reg   <= {negx_reg[1:0], neg_reg[0]};
            negy_reg   <= {negy_reg[1:0], neg_reg[1]};
            pcx_reg[1] <= pcx_reg[0];
            pcy_reg[1] <= pcy_reg[0];

            tx_reg     <= TW'(phx_reg) + TW'(plx_reg >> LS);
            ty_reg     <= TW'(phy_reg) + TW'(ply_reg >> LS);
            pcx_reg[2] <= pcx_reg[1];
            pcy_reg[2] <= pcy_reg[1];

            rx_reg     <= XW'((tx_reg + (TW'(1) << (RS - 1))) >> RS);
            ry_reg     <= XW'((ty_reg + (TW'(1) << (RS - 1))) >> RS);
            pcx_reg[3] <= pcx_reg[2];
            pcy_reg[3] <= pcy_reg[2];
        end
    end

    always_comb
    begin
        sum_x = negx_reg[2] ? SW'(pcx_reg[3]) - SW'({1'b0, rx_reg})
                            : SW'(pcx_reg[3]) + SW'({1'b0, rx_reg});
        sum_y = negy_reg[2] ? SW'(pcy_reg[3]) - SW'({1'b0, ry_reg})
                            : SW'(pcy_reg[3]) + SW'({1'b0, ry_reg});
        if (sum_x > SAT_HI)
            res_next.rotated_x = SAT_HI[CW-1:0];
        else if (sum_x < SAT_LO)
            res_next.rotated_x = SAT_LO[CW-1:0];
        else
            res_next.rotated_x = sum_x[CW-1:0];
        if (sum_y > SAT_HI)
            res_next.rotated_y = SAT_HI[CW-1:0];
        else if (sum_y < SAT_LO)
            res_next.rotated_y = SAT_LO[CW-1:0];
        else
            res_next.rotated_y = sum_y[CW-1:0];
    end

    always_comb
    begin
        case ({out_push, out_pop})
            2'b10:   ocnt_next = ocnt_reg + 2'd1;
            2'b01:   ocnt_next = ocnt_reg - 2'd1;
            default: ocnt_next = ocnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            owr_reg  <= owr_reg ^ out_push;
            ord_reg  <= ord_reg ^ out_pop;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            obuf_reg[owr_reg] <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pv_reg[3] && !advance) |=> (pv_reg[3] && $stable(rx_reg) && $stable(ry_reg)))
        else $error("last stage changed while stalled");

    a_obuf_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !out_pop) |=> (ocnt_reg == $past(ocnt_reg) + 2'd1))
        else $error("result buffer count did not follow a push");
`endif

endmodule
